// File: hdl/bra_pkg.sv
// Shared constants, types and helpers of the bitmap run allocator.
// Depends on nothing; every other file of the block imports it.
package bra_pkg;

  // Geometry of the usage map
  localparam int unsigned TOTAL_BITS = 4096;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned MAP_WORDS  = TOTAL_BITS / WORD_BITS;
  localparam int unsigned WORD_AW    = $clog2(WORD_BITS);
  localparam int unsigned MAP_AW     = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W      = $clog2(TOTAL_BITS);
  localparam int unsigned POS_W      = $clog2(TOTAL_BITS + 1);

  // Field widths of the channels and of the size register
  localparam int unsigned OPC_W   = 2;
  localparam int unsigned FIRST_W = 12;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned SIZE_W  = 13;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_MARK_USED = 2'd0;
  localparam logic [OPC_W-1:0] OP_MARK_FREE = 2'd1;
  localparam logic [OPC_W-1:0] OP_EXACT     = 2'd2;
  localparam logic [OPC_W-1:0] OP_PARTIAL   = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TOTAL_BITS);

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [FIRST_W-1:0] first_bit;
    logic [COUNT_W-1:0] count;
  } bra_req_t;

  typedef struct packed {
    logic               found;
    logic [FIRST_W-1:0] run_start;
    logic [COUNT_W-1:0] run_length;
  } bra_res_t;

  // Engine status towards the top level
  typedef struct packed {
    logic idle;
    logic done;
  } bra_stat_t;

  // Lowest set bit of a word: {hit, index}
  function automatic logic [WORD_AW:0] find_first(input logic [WORD_BITS-1:0] v);
    logic [WORD_AW:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, WORD_AW'(i)};
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/bra_if.sv
// Valid/ready channel interfaces of the bitmap run allocator.
// Depends on bra_pkg for the field widths.
interface bra_req_if import bra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  logic [FIRST_W-1:0] first_bit;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output opcode, output first_bit, output count,
                  input ready);
  modport sink   (input valid, input opcode, input first_bit, input count,
                  output ready);
endinterface

interface bra_rsp_if import bra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [FIRST_W-1:0] run_start;
  logic [COUNT_W-1:0] run_length;

  modport source (output valid, output found, output run_start, output run_length,
                  input ready);
  modport sink   (input valid, input found, input run_start, input run_length,
                  output ready);
endinterface

// File: hdl/bra_engine.sv
// Sequencer, usage map memory and shared word scanner of the allocator.
// Depends on bra_pkg.
module bra_engine import bra_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  bra_req_t         req_i,
  input  logic [POS_W-1:0] limit_i,
  input  logic             take_i,
  output bra_stat_t        stat_o,
  output bra_res_t         res_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_MSET  = 3'd3;
  localparam logic [2:0] ST_MRD   = 3'd4;
  localparam logic [2:0] ST_MWR   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [WORD_BITS-1:0] ONES = '1;

  logic [2:0]           state_q, state_d;
  logic                 in_run_q, in_run_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [BIT_W-1:0]     at_q, at_d;
  logic [OPC_W-1:0]     op_q, op_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 found_q, found_d;
  logic [BIT_W-1:0]     start_q, start_d;
  logic [COUNT_W-1:0]   len_q, len_d;
  logic [BIT_W-1:0]     mk_first_q, mk_first_d;
  logic [COUNT_W-1:0]   mk_count_q, mk_count_d;
  logic                 mk_set_q, mk_set_d;
  logic [BIT_W-1:0]     last_q, last_d;
  logic [MAP_AW-1:0]    w_q, w_d;

  // Usage map storage and per-word valid flags
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic [MAP_AW-1:0]    rd_addr;
  logic                 mem_we;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] word;

  // Scanner signals
  logic [POS_W-1:0]     word_base, seg_next, seg_end, found_pos, edge_pos, run;
  logic [WORD_BITS-1:0] target;
  logic [WORD_AW:0]     ffs;
  logic                 at_lim, hit_in;

  // Mark signals
  logic [COUNT_W:0]     end_sum;
  logic [COUNT_W:0]     end_clip;
  logic [WORD_AW-1:0]   lo, hi;
  logic [WORD_BITS-1:0] mask;

  // Memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[w_q] <= wdata;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
  end

  // A word never written reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[w_q] <= 1'b1;
    end
  end

  assign word = rd_vld_q ? rd_data_q : '0;

  // Shared scanner: next boundary at or after pos within the searched bits
  assign word_base = {pos_q[POS_W-1:WORD_AW], WORD_AW'(0)};
  assign seg_next  = word_base + POS_W'(WORD_BITS);
  assign at_lim    = (seg_next >= limit_i);
  assign seg_end   = at_lim ? limit_i : seg_next;
  assign target    = (in_run_q ? word : ~word) & (ONES << pos_q[WORD_AW-1:0]);
  assign ffs       = find_first(target);
  assign found_pos = word_base | POS_W'(ffs[WORD_AW-1:0]);
  assign hit_in    = ffs[WORD_AW] && (found_pos < seg_end);
  assign edge_pos  = hit_in ? found_pos : seg_end;
  assign run       = edge_pos - POS_W'(at_q);

  // Range bounds and per-word mask for the mark sweep
  assign end_sum  = (COUNT_W+1)'(mk_first_q) + (COUNT_W+1)'(mk_count_q);
  assign end_clip = (end_sum > (COUNT_W+1)'(TOTAL_BITS)) ? (COUNT_W+1)'(TOTAL_BITS)
                                                          : end_sum;
  assign lo   = (w_q == mk_first_q[BIT_W-1:WORD_AW]) ? mk_first_q[WORD_AW-1:0] : '0;
  assign hi   = (w_q == last_q[BIT_W-1:WORD_AW]) ? last_q[WORD_AW-1:0] : '1;
  assign mask = (ONES << lo) & (ONES >> (WORD_AW'(WORD_BITS - 1) - hi));
  assign wdata = mk_set_q ? (word | mask) : (word & ~mask);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    in_run_d   = in_run_q;
    pos_d      = pos_q;
    at_d       = at_q;
    op_d       = op_q;
    count_d    = count_q;
    found_d    = found_q;
    start_d    = start_q;
    len_d      = len_q;
    mk_first_d = mk_first_q;
    mk_count_d = mk_count_q;
    mk_set_d   = mk_set_q;
    last_d     = last_q;
    w_d        = w_q;
    mem_we     = 1'b0;
    rd_addr    = pos_q[BIT_W-1:WORD_AW];
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d    = req_i.opcode;
          count_d = req_i.count;
          found_d = 1'b1;
          start_d = '0;
          len_d   = '0;
          if (req_i.opcode == OP_MARK_USED || req_i.opcode == OP_MARK_FREE) begin
            mk_first_d = req_i.first_bit;
            mk_count_d = req_i.count;
            mk_set_d   = (req_i.opcode == OP_MARK_USED);
            state_d    = ST_MSET;
          end else if (req_i.count == '0) begin
            state_d = ST_DONE;
          end else begin
            pos_d    = '0;
            in_run_d = 1'b0;
            state_d  = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!in_run_q) begin
          // look for the next free bit
          if (hit_in) begin
            in_run_d = 1'b1;
            at_d     = edge_pos[BIT_W-1:0];
            pos_d    = edge_pos;
          end else if (at_lim) begin
            found_d = (op_q != OP_EXACT);
            state_d = ST_DONE;
          end else begin
            pos_d   = seg_end;
            state_d = ST_FETCH;
          end
        end else if (run >= POS_W'(count_q)) begin
          // run long enough: take count bits from its start
          start_d    = at_q;
          len_d      = count_q;
          mk_first_d = at_q;
          mk_count_d = count_q;
          mk_set_d   = 1'b1;
          state_d    = ST_MSET;
        end else if (op_q == OP_PARTIAL && (hit_in || at_lim)) begin
          // partial allocate keeps the first run however short
          start_d    = at_q;
          len_d      = COUNT_W'(run);
          mk_first_d = at_q;
          mk_count_d = COUNT_W'(run);
          mk_set_d   = 1'b1;
          state_d    = ST_MSET;
        end else if (hit_in) begin
          in_run_d = 1'b0;
          pos_d    = edge_pos;
        end else if (at_lim) begin
          found_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          pos_d   = seg_end;
          state_d = ST_FETCH;
        end
      end
      ST_MSET: begin
        if (mk_count_q == '0) begin
          state_d = ST_DONE;
        end else begin
          last_d  = BIT_W'(end_clip - (COUNT_W+1)'(1));
          w_d     = mk_first_q[BIT_W-1:WORD_AW];
          state_d = ST_MRD;
        end
      end
      ST_MRD: begin
        rd_addr = w_q;
        state_d = ST_MWR;
      end
      ST_MWR: begin
        mem_we = 1'b1;
        if (w_q == last_q[BIT_W-1:WORD_AW]) begin
          state_d = ST_DONE;
        end else begin
          w_d     = w_q + MAP_AW'(1);
          state_d = ST_MRD;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      in_run_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_run_q <= in_run_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    at_q       <= at_d;
    op_q       <= op_d;
    count_q    <= count_d;
    found_q    <= found_d;
    start_q    <= start_d;
    len_q      <= len_d;
    mk_first_q <= mk_first_d;
    mk_count_q <= mk_count_d;
    mk_set_q   <= mk_set_d;
    last_q     <= last_d;
    w_q        <= w_d;
  end

  assign stat_o.idle      = (state_q == ST_IDLE);
  assign stat_o.done      = (state_q == ST_DONE);
  assign res_o.found      = found_q;
  assign res_o.run_start  = start_q;
  assign res_o.run_length = len_q;

  // Checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("item started while engine busy");

  a_scan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_FETCH) |-> pos_q < POS_W'(TOTAL_BITS))
    else $error("scan position beyond map");

  a_fail_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !found_q) |-> (op_q == OP_EXACT && len_q == '0))
    else $error("failure reported for an operation that cannot fail");

  a_len_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> len_q <= count_q)
    else $error("allocated run longer than requested");

  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MWR |-> (w_q >= mk_first_q[BIT_W-1:WORD_AW] &&
                           w_q <= last_q[BIT_W-1:WORD_AW]))
    else $error("mark sweep outside its range");

endmodule

// File: hdl/bitmap_run_allocator_top.sv
// Top level of the bitmap run allocator: channels, size register, result register.
// Depends on bra_pkg, bra_if and bra_engine.
//
// Usage: requests arrive on req_i (opcode, first_bit, count) and one result per
// request leaves on rsp_o (found, run_start, run_length), both valid/ready.
// bitmap_size is written through cfg_we_i / cfg_data_i; the user must do so only
// while the block is idle; the block does not enforce it. One request is worked
// on at a time; req_i.ready is high while the engine idles. Steps to a result:
//   mark used / mark free: a setup state, then a read and a write state for each
//   map word touched (only the setup state when count is zero).
//   allocate: a fetch and a scan state per word read, one more scan state per
//   free/used boundary inside a word, then the mark steps if a run is marked.
// The scanner reads one 32-bit word through the single memory read port and
// finds one boundary per cycle in it, so the rate depends on the map contents.
// Reset frees the whole map at once through per-word valid flags (no clearing
// pass) and sets bitmap_size to 4096.
// The result sits in an output register; while it waits the next request is
// still accepted, and a finished engine holds its result until that register
// is empty or is being drained.
module bitmap_run_allocator_top import bra_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bra_req_if.sink           req_i,
  bra_rsp_if.source         rsp_o,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_data_i
);

  logic [SIZE_W-1:0] size_q;
  logic [POS_W-1:0]  limit;
  logic              start;
  logic              take;
  bra_req_t          req;
  bra_stat_t         stat;
  bra_res_t          eng_res;
  logic              res_valid_q;
  bra_res_t          res_q;

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_data_i;
    end
  end

  // Clamp the searched size to the map
  assign limit = (size_q > SIZE_W'(TOTAL_BITS)) ? POS_W'(TOTAL_BITS) : POS_W'(size_q);

  // Request side
  assign req_i.ready   = stat.idle;
  assign start         = req_i.valid && stat.idle;
  assign req.opcode    = req_i.opcode;
  assign req.first_bit = req_i.first_bit;
  assign req.count     = req_i.count;

  bra_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req),
    .limit_i (limit),
    .take_i  (take),
    .stat_o  (stat),
    .res_o   (eng_res)
  );

  // Output register: load when empty or being drained
  assign take = stat.done && (!res_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (take) begin
      res_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= eng_res;
    end
  end

  assign rsp_o.valid      = res_valid_q;
  assign rsp_o.found      = res_q.found;
  assign rsp_o.run_start  = res_q.run_start;
  assign rsp_o.run_length = res_q.run_length;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench of the bitmap run allocator: directed and random requests, a local bitmap
// predictor and a field-by-field result check. Depends on bra_pkg, bra_if and the RTL top.
module tb;
  import bra_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SIZE_W-1:0] cfg_data_i;

  bra_req_if req_if ();
  bra_rsp_if rsp_if ();

  bitmap_run_allocator_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state: one bit per unit (1 = used) and the searched size
  logic [TOTAL_BITS-1:0] used_map;
  logic [SIZE_W-1:0]     search_size;

  bra_req_t    req_backlog[$];
  bra_res_t    expected_res[$];
  bra_req_t    offered;
  bra_res_t    want;
  int unsigned fail_cnt;
  int unsigned results_seen;
  int unsigned hold_left;
  bit          hold_done;
  bit          steady;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Set or clear a span of units, ignoring those beyond the map
  function automatic void mark_span(int unsigned first, int unsigned len, bit val);
    for (int unsigned i = first; i < first + len && i < TOTAL_BITS; i++) begin
      used_map[i] = val;
    end
  endfunction

  // Work out the result of one request and update the local bitmap
  function automatic bra_res_t alloc_predict(bra_req_t rq);
    int unsigned lim, run, at, len, start;
    bit          began;
    bra_res_t    res;
    lim   = (search_size > TOTAL_BITS) ? TOTAL_BITS : search_size;
    run   = 0;
    at    = 0;
    len   = 0;
    start = 0;
    began = 1'b0;
    res.found = 1'b1;
    case (rq.opcode)
      OP_MARK_USED: mark_span(rq.first_bit, rq.count, 1'b1);
      OP_MARK_FREE: mark_span(rq.first_bit, rq.count, 1'b0);
      OP_EXACT: begin
        for (int unsigned i = 0; i < lim && run < rq.count; i++) begin
          if (!used_map[i]) begin
            if (run == 0) at = i;
            run++;
          end else begin
            run = 0;
          end
        end
        if (run == rq.count) begin
          start = (rq.count == 0) ? 0 : at;
          len   = rq.count;
          mark_span(start, len, 1'b1);
        end else begin
          res.found = 1'b0;
        end
      end
      default: begin
        for (int unsigned i = 0; i < lim && len < rq.count; i++) begin
          if (!used_map[i]) begin
            if (!began) begin
              start = i;
              began = 1'b1;
            end
            len++;
          end else if (began) begin
            break;
          end
        end
        if (len == 0) start = 0;
        mark_span(start, len, 1'b1);
      end
    endcase
    res.run_start  = FIRST_W'(start);
    res.run_length = COUNT_W'(len);
    return res;
  endfunction

  // Random request, mostly near the searched region with modest counts
  function automatic bra_req_t random_request(int unsigned size);
    int unsigned span, pick;
    bra_req_t    rq;
    span = (size > TOTAL_BITS) ? TOTAL_BITS : size;
    if (span < 64) span = 64;
    pick = $urandom_range(0, 99);
    rq.first_bit = FIRST_W'($urandom_range(0, span - 1));
    if (pick < 20) begin
      rq.opcode = OP_MARK_USED;
      rq.count  = COUNT_W'($urandom_range(0, 40));
    end else if (pick < 40) begin
      rq.opcode = OP_MARK_FREE;
      rq.count  = COUNT_W'($urandom_range(0, 80));
    end else if (pick < 65) begin
      rq.opcode = OP_EXACT;
      rq.count  = ($urandom_range(0, 19) == 0) ? COUNT_W'($urandom_range(0, 8191))
                                               : COUNT_W'($urandom_range(0, 24));
    end else if (pick < 90) begin
      rq.opcode = OP_PARTIAL;
      rq.count  = ($urandom_range(0, 9) == 0) ? COUNT_W'(8191)
                                              : COUNT_W'($urandom_range(0, 48));
    end else if (pick < 93) begin
      rq.opcode    = OP_MARK_FREE;
      rq.first_bit = '0;
      rq.count     = COUNT_W'(TOTAL_BITS);
    end else begin
      rq.opcode    = OPC_W'($urandom);
      rq.first_bit = FIRST_W'($urandom);
      rq.count     = COUNT_W'($urandom);
    end
    return rq;
  endfunction

  task automatic push_req(logic [OPC_W-1:0] op, int unsigned first, int unsigned cnt);
    bra_req_t rq;
    rq.opcode    = op;
    rq.first_bit = FIRST_W'(first);
    rq.count     = COUNT_W'(cnt);
    req_backlog.push_back(rq);
  endtask

  // Wait until every item has gone through and every result has come back
  task automatic drain();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || req_if.valid || expected_res.size() != 0);
  endtask

  task automatic write_size(int unsigned val);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_data_i  <= SIZE_W'(val);
    search_size  = SIZE_W'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Driver: offer items from the backlog, holding each until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) expected_res.push_back(alloc_predict(offered));
      if (!req_if.valid || req_if.ready) begin
        if (req_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 34)) begin
          offered = req_backlog.pop_front();
          req_if.valid     <= 1'b1;
          req_if.opcode    <= offered.opcode;
          req_if.first_bit <= offered.first_bit;
          req_if.count     <= offered.count;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      results_seen  = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result found=%0d start=%0d length=%0d", $time,
                   rsp_if.found, rsp_if.run_start, rsp_if.run_length);
          fail_cnt++;
        end else begin
          want = expected_res.pop_front();
          if (rsp_if.found !== want.found) begin
            $display("%0t: found mismatch: expected %0d, actual %0d", $time,
                     want.found, rsp_if.found);
            fail_cnt++;
          end
          if (rsp_if.run_start !== want.run_start) begin
            $display("%0t: run_start mismatch: expected %0d, actual %0d", $time,
                     want.run_start, rsp_if.run_start);
            fail_cnt++;
          end
          if (rsp_if.run_length !== want.run_length) begin
            $display("%0t: run_length mismatch: expected %0d, actual %0d", $time,
                     want.run_length, rsp_if.run_length);
            fail_cnt++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (results_seen == 300 && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // Stimulus: directed cases at the reset size, then random phases at eight sizes
  initial begin
    int unsigned phase_size[8];
    int unsigned n_items;
    phase_size = '{0, 1, 33, 300, 4097, 8191, 4096, 1024};
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    req_if.valid     = 1'b0;
    req_if.opcode    = '0;
    req_if.first_bit = '0;
    req_if.count     = '0;
    rsp_if.ready     = 1'b0;
    fail_cnt         = 0;
    steady           = 1'b0;
    used_map         = '0;
    search_size      = SIZE_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero counts, whole-map allocation, full map, last bit, clipped ranges
    push_req(OP_EXACT, 0, 0);
    push_req(OP_PARTIAL, 0, 0);
    push_req(OP_EXACT, 0, 4096);
    push_req(OP_PARTIAL, 0, 5);
    push_req(OP_EXACT, 0, 1);
    push_req(OP_MARK_FREE, 4095, 1);
    push_req(OP_EXACT, 0, 1);
    push_req(OP_MARK_FREE, 0, 4096);
    push_req(OP_MARK_USED, 4000, 8191);
    push_req(OP_MARK_USED, 0, 0);
    push_req(OP_PARTIAL, 0, 8191);
    // Holes of different sizes: first fit, short partial run, exact miss and hit
    push_req(OP_MARK_FREE, 100, 50);
    push_req(OP_MARK_FREE, 300, 10);
    push_req(OP_EXACT, 0, 20);
    push_req(OP_PARTIAL, 0, 100);
    push_req(OP_EXACT, 0, 11);
    push_req(OP_EXACT, 0, 10);
    push_req(OP_MARK_FREE, 4095, 8191);
    push_req(OP_MARK_FREE, 2048, 1);
    push_req(OP_PARTIAL, 0, 3);
    push_req(OP_MARK_FREE, 0, 8191);

    foreach (phase_size[p]) begin
      write_size(phase_size[p]);
      @(negedge clk_i);
      steady  = (phase_size[p] == 300);
      n_items = (phase_size[p] < 32) ? 40 : 130;
      repeat (n_items) req_backlog.push_back(random_request(phase_size[p]));
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Give up well beyond the slowest legal run (full-map scans on every item)
  initial begin
    #300_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
